// ===== hw/rtl/mvma_pkg.sv =====
// Shared types and constants of the matrix-vector multiply-accumulate block.
// Holds the command, result, load and chain token structs and the fixed widths.
// No dependencies; the cell, output stage and top level refer to it by scoped names.
package mvma_pkg;

	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int MAX_DIM   = 16;
	localparam int IDX_W     = 4;
	localparam int DIM_W     = 5;
	localparam int ACC_W     = 40;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [DATA_W-1:0] ALPHA_ONE = DATA_W'(1 << FRAC_BITS);

	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd4;

	typedef enum logic [1:0] {
		MODE_MAT     = 2'd0,
		MODE_X       = 2'd1,
		MODE_Y       = 2'd2,
		MODE_COMPUTE = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [DATA_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]          index;
		logic signed [DATA_W-1:0]  result;
		logic                      last;
	} res_t;

	// Load bus broadcast to the cells and to the output stage.
	typedef struct packed {
		logic                      mat_we;
		logic                      x_we;
		logic                      y_we;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [DATA_W-1:0]  value;
	} ld_t;

	// Partial sum of one y element travelling down the chain.
	typedef struct packed {
		logic                      valid;
		logic                      last;
		logic [IDX_W-1:0]          k;
		logic signed [ACC_W-1:0]   sum;
	} tok_t;

endpackage

// ===== hw/rtl/mvma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the matrix storage of each cell and for the y vector.
module mvma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/mvma_cell.sv =====
// One cell of the multiply-accumulate chain: holds one x element, one matrix
// column and one matrix row, and adds its product to the passing partial sum.
// Depends on mvma_pkg and mvma_ram.
module mvma_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mvma_pkg::IDX_W-1:0]   idx,
	input  mvma_pkg::ld_t                ld,
	input  logic                         transpose,
	input  logic [mvma_pkg::DIM_W-1:0]   lenx,
	input  mvma_pkg::tok_t               tok_in,
	output mvma_pkg::tok_t               tok_out
);

	localparam int RAM_DEPTH = 2 * mvma_pkg::MAX_DIM;
	localparam int RAM_AW    = mvma_pkg::IDX_W + 1;

	logic                                  col_hit;
	logic                                  row_hit;
	logic                                  ram_we;
	logic [RAM_AW-1:0]                     ram_waddr;
	logic [RAM_AW-1:0]                     ram_raddr;
	logic [mvma_pkg::DATA_W-1:0]           ram_rdata;
	logic                                  en;
	logic signed [mvma_pkg::DATA_W-1:0]    x_q;
	mvma_pkg::tok_t                        tok_s1;
	mvma_pkg::tok_t                        tok_s2;
	mvma_pkg::tok_t                        tok_q;
	logic signed [mvma_pkg::PROD_W-1:0]    prod_s2;

	// Lower page holds column idx by row, upper page holds row idx by column.
	// The diagonal element lives only in the lower page.
	assign col_hit   = ld.mat_we && (ld.col == idx);
	assign row_hit   = ld.mat_we && (ld.row == idx) && (ld.col != idx);
	assign ram_we    = col_hit || row_hit;
	assign ram_waddr = col_hit ? {1'b0, ld.row} : {1'b1, ld.col};
	assign ram_raddr = {transpose && (tok_in.k != idx), tok_in.k};
	assign en        = ({1'b0, idx} < lenx);

	mvma_ram #(
		.WIDTH (mvma_pkg::DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ld.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ld.x_we && (ld.row == idx)) begin
			x_q <= ld.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			tok_s2  <= '0;
			tok_q   <= '0;
			prod_s2 <= '0;
		end else begin
			tok_s1  <= tok_in;
			tok_s2  <= tok_s1;
			prod_s2 <= en ? (mvma_pkg::PROD_W'($signed(ram_rdata)) * mvma_pkg::PROD_W'(x_q))
			              : '0;
			tok_q.valid <= tok_s2.valid;
			tok_q.last  <= tok_s2.last;
			tok_q.k     <= tok_s2.k;
			tok_q.sum   <= tok_s2.sum + mvma_pkg::ACC_W'(prod_s2);
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/mvma_post.sv =====
// Output stage: scales the finished product sum by alpha, adds beta times the
// old y element, rounds, saturates, writes y back and drives the result.
// If empty, y passes through unwritten. Depends on mvma_pkg and mvma_ram.
module mvma_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [mvma_pkg::DATA_W-1:0]  alpha,
	input  logic signed [mvma_pkg::DATA_W-1:0]  beta,
	input  logic                                empty,
	input  mvma_pkg::ld_t                       ld,
	input  mvma_pkg::tok_t                      tok_in,
	output logic                                res_valid,
	output mvma_pkg::res_t                      res
);

	localparam int SPLIT = 20;
	localparam int HI_W  = mvma_pkg::ACC_W - SPLIT;
	localparam int MUL_HI_W = mvma_pkg::DATA_W + HI_W;
	localparam int MUL_LO_W = mvma_pkg::DATA_W + SPLIT + 1;
	localparam int TOT_W = mvma_pkg::ACC_W + mvma_pkg::DATA_W;
	localparam int SHIFT = 2 * mvma_pkg::FRAC_BITS;
	localparam logic signed [TOT_W-1:0] HALF =
		(SHIFT > 0) ? TOT_W'(64'sd1 <<< (SHIFT - 1)) : '0;

	logic [mvma_pkg::DATA_W-1:0]                 y_rdata;
	logic                                        y_we;
	logic [mvma_pkg::IDX_W-1:0]                  y_waddr;
	logic signed [mvma_pkg::DATA_W-1:0]          y_wdata;
	logic signed [mvma_pkg::DATA_W-1:0]          scaled;

	mvma_pkg::tok_t                              tok_p1;
	logic                                        vld_p2, last_p2;
	logic [mvma_pkg::IDX_W-1:0]                  k_p2;
	logic signed [MUL_HI_W-1:0]                  mul_hi_p2;
	logic signed [MUL_LO_W-1:0]                  mul_lo_p2;
	logic signed [mvma_pkg::PROD_W-1:0]          by_p2;
	logic signed [mvma_pkg::DATA_W-1:0]          y_p2;
	logic                                        vld_p3, last_p3;
	logic [mvma_pkg::IDX_W-1:0]                  k_p3;
	logic signed [TOT_W-1:0]                     tot_p3;
	logic signed [mvma_pkg::DATA_W-1:0]          y_p3;
	logic signed [TOT_W-1:0]                     shifted;
	logic                                        res_valid_q;
	mvma_pkg::res_t                              res_q;

	// Clips to the signed data range: the bits above the result must all
	// copy its sign bit.
	function automatic logic signed [mvma_pkg::DATA_W-1:0] sat(
		input logic signed [TOT_W-1:0] v
	);
		logic [TOT_W-mvma_pkg::DATA_W:0] top;
		top = v[TOT_W-1:mvma_pkg::DATA_W-1];
		if ((&top) || !(|top)) begin
			return v[mvma_pkg::DATA_W-1:0];
		end
		return v[TOT_W-1] ? {1'b1, {(mvma_pkg::DATA_W-1){1'b0}}}
		                  : {1'b0, {(mvma_pkg::DATA_W-1){1'b1}}};
	endfunction

	assign shifted = tot_p3 >>> SHIFT;
	assign scaled  = sat(shifted);

	// Loads and write-backs never meet: loads are taken only while idle.
	assign y_we    = ld.y_we || (vld_p3 && !empty);
	assign y_waddr = ld.y_we ? ld.row : k_p3;
	assign y_wdata = ld.y_we ? ld.value : scaled;

	mvma_ram #(
		.WIDTH (mvma_pkg::DATA_W),
		.DEPTH (mvma_pkg::MAX_DIM)
	) u_yram (
		.clk   (clk),
		.we    (y_we),
		.waddr (y_waddr),
		.wdata (y_wdata),
		.raddr (tok_in.k),
		.rdata (y_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_p1      <= '0;
			vld_p2      <= 1'b0;
			vld_p3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			tok_p1      <= tok_in;
			vld_p2      <= tok_p1.valid;
			vld_p3      <= vld_p2;
			res_valid_q <= vld_p3;
		end
	end

	// The 40-bit sum is split so that each multiplier stays narrow.
	always_ff @(posedge clk) begin
		last_p2   <= tok_p1.last;
		k_p2      <= tok_p1.k;
		mul_hi_p2 <= MUL_HI_W'(alpha)
		           * MUL_HI_W'($signed(tok_p1.sum[mvma_pkg::ACC_W-1:SPLIT]));
		mul_lo_p2 <= MUL_LO_W'(alpha) * MUL_LO_W'($signed({1'b0, tok_p1.sum[SPLIT-1:0]}));
		by_p2     <= (beta == '0) ? '0
		           : (mvma_pkg::PROD_W'(beta) * mvma_pkg::PROD_W'($signed(y_rdata)));
		y_p2      <= $signed(y_rdata);

		last_p3   <= last_p2;
		k_p3      <= k_p2;
		y_p3      <= y_p2;
		tot_p3    <= (TOT_W'(mul_hi_p2) <<< SPLIT) + TOT_W'(mul_lo_p2)
		           + (TOT_W'(by_p2) <<< mvma_pkg::FRAC_BITS) + HALF;

		res_q.index  <= k_p3;
		res_q.last   <= last_p3;
		res_q.result <= empty ? y_p3 : scaled;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/matrix_vector_multiply_accumulate.sv =====
// Top level of the matrix-vector multiply-accumulate block (y = alpha*op(A)*x + beta*y).
// Depends on mvma_pkg, mvma_cell and mvma_post.
//
// Use: commands come on cmd and are transferred at a rising edge with start
// high and busy low. A load command (matrix, x or y element) is written at that
// edge and leaves busy low, so loads stream at one per cycle. A compute command
// raises busy and returns leny result transfers on res, one per cycle, each
// marked by res_valid for exactly one cycle; the final one has last set.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// The first result of a compute passes through three registers in each of the
// 16 cells plus four in the output stage, the others follow back to back, and
// busy falls after the last result. A compute with leny of zero returns nothing
// and leaves busy low. The configuration channel (cfg_valid, cfg_index,
// cfg_data) is always ready; the user must use it only while the block is idle,
// as the block itself does not enforce this.
// Reset clears busy, the pipeline and the configuration registers (alpha to 1.0);
// the matrix, x and y stores hold nothing defined until loaded.
module matrix_vector_multiply_accumulate (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  mvma_pkg::cmd_t                         cmd,
	output logic                                   res_valid,
	output mvma_pkg::res_t                         res,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mvma_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mvma_pkg::DATA_W-1:0]            cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t                                 state_q;
	logic                                   transpose_q;
	logic [mvma_pkg::DIM_W-1:0]             rows_q;
	logic [mvma_pkg::DIM_W-1:0]             cols_q;
	logic signed [mvma_pkg::DATA_W-1:0]     alpha_q;
	logic signed [mvma_pkg::DATA_W-1:0]     beta_q;
	logic [mvma_pkg::IDX_W-1:0]             k_q;
	logic [mvma_pkg::DIM_W-1:0]             leny_q;
	logic [mvma_pkg::DIM_W-1:0]             lenx_q;
	logic                                   empty_q;

	logic                                   accept;
	logic                                   go;
	logic [mvma_pkg::DIM_W-1:0]             m_dim;
	logic [mvma_pkg::DIM_W-1:0]             n_dim;
	logic [mvma_pkg::DIM_W-1:0]             leny_d;
	logic [mvma_pkg::DIM_W-1:0]             lenx_d;
	logic                                   issue_last;
	mvma_pkg::ld_t                          ld;
	mvma_pkg::tok_t                         chain [mvma_pkg::MAX_DIM+1];

	// The configuration channel never back-pressures.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
			rows_q      <= '0;
			cols_q      <= '0;
			alpha_q     <= mvma_pkg::ALPHA_ONE;
			beta_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mvma_pkg::CFG_TRANSPOSE: transpose_q <= cfg_data[0];
				mvma_pkg::CFG_ROWS:      rows_q      <= cfg_data[mvma_pkg::DIM_W-1:0];
				mvma_pkg::CFG_COLS:      cols_q      <= cfg_data[mvma_pkg::DIM_W-1:0];
				mvma_pkg::CFG_ALPHA:     alpha_q     <= $signed(cfg_data);
				mvma_pkg::CFG_BETA:      beta_q      <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Command decode. A transfer happens only while idle, so loads never
	// collide with the compute traffic inside the cells or the y store.
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign go     = accept && (cmd.mode == mvma_pkg::MODE_COMPUTE);

	assign ld.mat_we = accept && (cmd.mode == mvma_pkg::MODE_MAT);
	assign ld.x_we   = accept && (cmd.mode == mvma_pkg::MODE_X);
	assign ld.y_we   = accept && (cmd.mode == mvma_pkg::MODE_Y);
	assign ld.row    = cmd.row;
	assign ld.col    = cmd.col;
	assign ld.value  = cmd.value;

	// Dimensions beyond the array size are clamped to it. Without transpose y
	// has one element per row and x one per column; transpose swaps the two.
	assign m_dim  = (rows_q > mvma_pkg::DIM_W'(mvma_pkg::MAX_DIM))
	              ? mvma_pkg::DIM_W'(mvma_pkg::MAX_DIM) : rows_q;
	assign n_dim  = (cols_q > mvma_pkg::DIM_W'(mvma_pkg::MAX_DIM))
	              ? mvma_pkg::DIM_W'(mvma_pkg::MAX_DIM) : cols_q;
	assign leny_d = transpose_q ? n_dim : m_dim;
	assign lenx_d = transpose_q ? m_dim : n_dim;

	assign issue_last = (({1'b0, k_q} + mvma_pkg::DIM_W'(1)) == leny_q);

	// Sequencer: feeds one y index a cycle into the head of the chain, then
	// waits until the output stage has shown the marked final result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			leny_q  <= '0;
			lenx_q  <= '0;
			empty_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						k_q     <= '0;
						leny_q  <= leny_d;
						lenx_q  <= lenx_d;
						empty_q <= (m_dim == '0) || (n_dim == '0);
						if (leny_d != '0) begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + mvma_pkg::IDX_W'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res_valid && res.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Head of the chain: each y index enters with a zero partial sum. Cell t
	// adds op(A)[k][t] * x[t]; cells at or beyond the x length add nothing,
	// so every sum passes through all the cells before it leaves the far end.
	assign chain[0].valid = (state_q == ST_ISSUE);
	assign chain[0].last  = issue_last;
	assign chain[0].k     = k_q;
	assign chain[0].sum   = '0;

	for (genvar g = 0; g < mvma_pkg::MAX_DIM; g++) begin : g_cell
		mvma_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (mvma_pkg::IDX_W'(g)),
			.ld        (ld),
			.transpose (transpose_q),
			.lenx      (lenx_q),
			.tok_in    (chain[g]),
			.tok_out   (chain[g+1])
		);
	end

	// Scaling, rounding, saturation and y write-back. When either dimension
	// is zero the stored y elements pass through unchanged.
	mvma_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.alpha     (alpha_q),
		.beta      (beta_q),
		.empty     (empty_q),
		.ld        (ld),
		.tok_in    (chain[mvma_pkg::MAX_DIM]),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
